### rtl/tacs_pkg.sv
// Shared types, codes and widths for the tiny accumulator CPU step block.
// No dependencies; imported by tacs_exec, the top level and the testbench.
package tacs_pkg;

    localparam int BYTE_W        = 8;
    localparam int MEM_DEPTH_DEF = 256;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int S_TDATA_W     = 16;  // addr, data
    localparam int M_TDATA_W     = 40;  // 35 bits of fields, padded to bytes
    localparam int M_FIELDS_W    = 35;

    // Request function, carried on s_axis_tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR = 2'd0,
        FN_WRITE = 2'd1,
        FN_EXEC  = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_HALT    = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    typedef enum logic [BYTE_W-1:0] {
        OP_HALT  = 8'd0,
        OP_LDA   = 8'd1,
        OP_ADDI  = 8'd2,
        OP_LDB   = 8'd3,
        OP_ADDB  = 8'd4,
        OP_MOVAB = 8'd5,
        OP_JMP   = 8'd6,
        OP_JZ    = 8'd7
    } t_opcode;

    // Architectural registers
    typedef struct packed {
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] breg;
        logic              zflag;
        logic [BYTE_W-1:0] pc;
    } t_cpu_state;

endpackage

### rtl/tacs_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module tacs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    // read-before-write on a clash
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

### rtl/tacs_exec.sv
// Single-pass execute unit: next register state, status and fetched opcode.
// Depends on tacs_pkg.
module tacs_exec
    import tacs_pkg::*;
(
    input  logic [FUNC_W-1:0]   i_func,
    input  t_cpu_state          i_state,
    input  logic [BYTE_W-1:0]   i_op,
    input  logic [BYTE_W-1:0]   i_opnd,
    output t_cpu_state          o_state,
    output logic [BYTE_W-1:0]   o_fetched_op,
    output logic [STATUS_W-1:0] o_status
);

    logic [BYTE_W-1:0] pc_inc1;
    logic [BYTE_W-1:0] pc_inc2;
    logic [BYTE_W-1:0] sum_imm;
    logic [BYTE_W-1:0] sum_b;

    assign pc_inc1 = i_state.pc + BYTE_W'(1);
    assign pc_inc2 = i_state.pc + BYTE_W'(2);
    assign sum_imm = i_state.acc + i_opnd;
    assign sum_b   = i_state.acc + i_state.breg;

    always_comb begin
        o_state      = i_state;
        o_fetched_op = '0;
        o_status     = ST_OK;
        unique case (i_func)
            FN_CLEAR: begin
                o_state = '0;
            end
            FN_WRITE: begin
                o_state = i_state;
            end
            FN_EXEC: begin
                o_fetched_op = i_op;
                o_state.pc   = pc_inc1;
                unique case (i_op)
                    OP_HALT: o_status = ST_HALT;
                    OP_LDA: begin
                        o_state.acc = i_opnd;
                        o_state.pc  = pc_inc2;
                    end
                    OP_ADDI: begin
                        o_state.acc   = sum_imm;
                        o_state.zflag = (sum_imm == '0);
                        o_state.pc    = pc_inc2;
                    end
                    OP_LDB: begin
                        o_state.breg = i_opnd;
                        o_state.pc   = pc_inc2;
                    end
                    OP_ADDB: begin
                        o_state.acc   = sum_b;
                        o_state.zflag = (sum_b == '0);
                    end
                    OP_MOVAB: o_state.breg = i_state.acc;
                    OP_JMP:   o_state.pc   = i_opnd;
                    OP_JZ:    o_state.pc   = i_state.zflag ? i_opnd : pc_inc2;
                    default:  o_status     = ST_UNKNOWN;
                endcase
            end
            default: begin
                o_state = i_state;  // unused code: no change
            end
        endcase
    end

endmodule

### rtl/tiny_accumulator_cpu_step.sv
// Tiny accumulator CPU step block: top level, stream ports and program memory.
// Depends on tacs_pkg, tacs_ram and tacs_exec.
// Latency: a request accepted at one edge shows its result on m_axis from the next cycle.
// One request per cycle unless m_axis stalls; limit: opcode/operand fetch and 8-bit add.
// Reset (i_rst_n low, synchronous): registers, PC and memory valid bits cleared, output empty.
// Memory reads back as zero after reset or a clear request until a byte is written.
module tiny_accumulator_cpu_step
    import tacs_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] addr, [15:8] data
    input  logic [FUNC_W-1:0]    s_axis_tuser,   // [1:0] func
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // [7:0] reg_a, [15:8] reg_b,
                                                 // [16] zero_flag, [24:17] prog_counter,
                                                 // [32:25] fetched_op, [34:33] status,
                                                 // [39:35] zero
);

    localparam int ADDR_W = $clog2(MEM_DEPTH);

    logic              accept;
    logic [BYTE_W-1:0] req_addr;
    logic [BYTE_W-1:0] req_data;
    logic              do_write;
    logic              do_clear;

    // architectural state
    t_cpu_state r_state;
    t_cpu_state n_state;
    t_cpu_state exec_state;

    // per-entry valid bits stand in for the zeroed memory
    logic [MEM_DEPTH-1:0] r_valid;

    // bookkeeping for bytes fetched with registered reads
    logic              r_vld0;
    logic              r_vld1;
    logic              r_byp_wr;
    logic              r_byp_clr;
    logic [ADDR_W-1:0] r_byp_addr;
    logic [BYTE_W-1:0] r_byp_data;

    logic [BYTE_W-1:0] ram_q0;
    logic [BYTE_W-1:0] ram_q1;
    logic [BYTE_W-1:0] n_pc_inc;
    logic [ADDR_W-1:0] raddr0;
    logic [ADDR_W-1:0] raddr1;
    logic [ADDR_W-1:0] cur_a0;
    logic [ADDR_W-1:0] cur_a1;
    logic [BYTE_W-1:0] op_byte;
    logic [BYTE_W-1:0] opnd_byte;

    logic [BYTE_W-1:0]   exec_fetched;
    logic [STATUS_W-1:0] exec_status;

    // output register
    logic                  r_out_valid;
    logic [M_FIELDS_W-1:0] r_out_fields;

    assign req_addr = s_axis_tdata[BYTE_W-1:0];
    assign req_data = s_axis_tdata[2*BYTE_W-1:BYTE_W];

    // take a new request whenever the output register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign do_write      = accept && (s_axis_tuser == FN_WRITE);
    assign do_clear      = accept && (s_axis_tuser == FN_CLEAR);

    // The RAM is always reading at the PC that will hold next cycle, so the
    // opcode and operand bytes are ready when the next request turns up.
    assign n_state  = accept ? exec_state : r_state;
    assign n_pc_inc = n_state.pc + BYTE_W'(1);
    assign raddr0   = n_state.pc[ADDR_W-1:0];
    assign raddr1   = n_pc_inc[ADDR_W-1:0];

    tacs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (do_write),
        .i_waddr  (req_addr[ADDR_W-1:0]),
        .i_wdata  (req_data),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (ram_q0),
        .o_rdata1 (ram_q1)
    );

    // Fix up the registered read data: a clear or write taken in the same
    // cycle as the read is not seen by the RAM output, so patch it here.
    assign cur_a0 = r_state.pc[ADDR_W-1:0];
    assign cur_a1 = cur_a0 + ADDR_W'(1);

    always_comb begin
        if (r_byp_clr) begin
            op_byte = '0;
        end else if (r_byp_wr && (r_byp_addr == cur_a0)) begin
            op_byte = r_byp_data;
        end else begin
            op_byte = r_vld0 ? ram_q0 : '0;
        end

        if (r_byp_clr) begin
            opnd_byte = '0;
        end else if (r_byp_wr && (r_byp_addr == cur_a1)) begin
            opnd_byte = r_byp_data;
        end else begin
            opnd_byte = r_vld1 ? ram_q1 : '0;
        end
    end

    tacs_exec u_exec (
        .i_func       (s_axis_tuser),
        .i_state      (r_state),
        .i_op         (op_byte),
        .i_opnd       (opnd_byte),
        .o_state      (exec_state),
        .o_fetched_op (exec_fetched),
        .o_status     (exec_status)
    );

    // state, valid bits and read bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= '0;
            r_valid    <= '0;
            r_vld0     <= 1'b0;
            r_vld1     <= 1'b0;
            r_byp_wr   <= 1'b0;
            r_byp_clr  <= 1'b1;  // memory reads as zero straight out of reset
        end else begin
            r_state   <= n_state;
            r_vld0    <= r_valid[raddr0];
            r_vld1    <= r_valid[raddr1];
            r_byp_wr  <= do_write;
            r_byp_clr <= do_clear;
            if (do_clear) begin
                r_valid <= '0;
            end else if (do_write) begin
                r_valid[req_addr[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_addr <= req_addr[ADDR_W-1:0];
        r_byp_data <= req_data;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_fields <= {exec_status, exec_fetched, exec_state.pc,
                             exec_state.zflag, exec_state.breg, exec_state.acc};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), r_out_fields};

endmodule

### dv/tb_tiny_accumulator_cpu_step.sv
// Self-checking testbench for tiny_accumulator_cpu_step: streams clear, write and execute
// requests, predicts every result in SystemVerilog and checks them in order.
// Depends on tacs_pkg and the tiny_accumulator_cpu_step RTL.
`timescale 1ns / 1ps

module tb_tiny_accumulator_cpu_step;
    import tacs_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;  // a correct run ends well before this limit
    localparam int TAIL_CYCLES = 10;       // a result shows in the cycle after its request is accepted

    // spare function code, outside t_func: the block leaves its state unchanged
    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

    // One result as packed on m_axis_tdata, lowest field last here
    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] fetched_op;
        logic [BYTE_W-1:0] prog_counter;
        logic              zero_flag;
        logic [BYTE_W-1:0] reg_b;
        logic [BYTE_W-1:0] reg_a;
    } t_cpu_result;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_request;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [7:0] addr, [15:8] data
    logic [FUNC_W-1:0]    s_axis_tuser  = '0;  // [1:0] func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [7:0] reg_a, [15:8] reg_b, [16] zero_flag,
                                               // [24:17] prog_counter, [32:25] fetched_op,
                                               // [34:33] status, [39:35] zero

    tiny_accumulator_cpu_step DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow CPU: its own registers and memory, stepped per accepted request
    // ---------------------------------------------------------------
    logic [BYTE_W-1:0] cpu_acc;
    logic [BYTE_W-1:0] cpu_breg;
    logic              cpu_zero;
    logic [BYTE_W-1:0] cpu_pc;
    logic [BYTE_W-1:0] cpu_mem [MEM_DEPTH_DEF];

    function automatic void clear_cpu();
        cpu_acc  = '0;
        cpu_breg = '0;
        cpu_zero = 1'b0;
        cpu_pc   = '0;
        foreach (cpu_mem[i]) cpu_mem[i] = '0;
    endfunction

    function automatic t_cpu_result step_cpu(logic [FUNC_W-1:0] func,
                                             logic [BYTE_W-1:0] addr,
                                             logic [BYTE_W-1:0] data);
        t_cpu_result       res;
        logic [BYTE_W-1:0] op;
        logic [BYTE_W-1:0] operand;
        op         = '0;
        res.status = ST_OK;
        case (func)
            FN_CLEAR: begin
                clear_cpu();
            end
            FN_WRITE: begin
                cpu_mem[addr] = data;
            end
            FN_EXEC: begin
                op      = cpu_mem[cpu_pc];
                cpu_pc  = cpu_pc + 8'd1;       // wraps at 256
                operand = cpu_mem[cpu_pc];
                case (op)
                    OP_HALT:  res.status = ST_HALT;
                    OP_LDA: begin
                        cpu_acc = operand;
                        cpu_pc  = cpu_pc + 8'd1;
                    end
                    OP_ADDI: begin
                        cpu_acc  = cpu_acc + operand;
                        cpu_zero = (cpu_acc == '0);
                        cpu_pc   = cpu_pc + 8'd1;
                    end
                    OP_LDB: begin
                        cpu_breg = operand;
                        cpu_pc   = cpu_pc + 8'd1;
                    end
                    OP_ADDB: begin
                        cpu_acc  = cpu_acc + cpu_breg;
                        cpu_zero = (cpu_acc == '0);
                    end
                    OP_MOVAB: cpu_breg = cpu_acc;
                    OP_JMP:   cpu_pc   = operand;
                    OP_JZ: begin
                        // taken on Z set, otherwise step over the target byte
                        if (cpu_zero) cpu_pc = operand;
                        else          cpu_pc = cpu_pc + 8'd1;
                    end
                    default:  res.status = ST_UNKNOWN;
                endcase
            end
            default: ;  // spare function code: nothing changes
        endcase
        res.reg_a        = cpu_acc;
        res.reg_b        = cpu_breg;
        res.zero_flag    = cpu_zero;
        res.prog_counter = cpu_pc;
        res.fetched_op   = op;
        return res;
    endfunction

    initial clear_cpu();

    // ---------------------------------------------------------------
    // Request queue, expected results and bookkeeping
    // ---------------------------------------------------------------
    t_request    request_q[$];
    t_cpu_result expected_regs_q[$];
    int          requests_queued = 0;
    int          results_checked = 0;
    int          mismatch_count  = 0;
    int          cycle_count     = 0;
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    bit          request_taken   = 1'b0;   // handshake seen at the last rising edge

    // ---------------------------------------------------------------
    // Driver: new request and tready are applied at the falling edge
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || request_taken) begin
                if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {req.data, req.addr};
                    s_axis_tuser  <= req.func;
                end else begin
                    // idle: junk on the data lines, valid low
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata  <= S_TDATA_W'($urandom);
                    s_axis_tuser  <= FUNC_W'($urandom);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: results are checked before the request of the same edge
    // is predicted, so a result never meets its own expectation early
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cpu_result got;
        t_cpu_result want;
        request_taken = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_cpu_result'(m_axis_tdata[M_FIELDS_W-1:0]);
                if (expected_regs_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with nothing outstanding: %h", $realtime,
                                 m_axis_tdata);
                end else begin
                    want = expected_regs_q.pop_front();
                    results_checked++;
                    if (got.reg_a !== want.reg_a || got.reg_b !== want.reg_b ||
                        got.zero_flag !== want.zero_flag ||
                        got.prog_counter !== want.prog_counter ||
                        got.fetched_op !== want.fetched_op || got.status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: mismatch exp a=%h b=%h z=%b pc=%h op=%h st=%0d",
                                     $realtime, want.reg_a, want.reg_b, want.zero_flag,
                                     want.prog_counter, want.fetched_op, want.status);
                            $display("%0t:          got a=%h b=%h z=%b pc=%h op=%h st=%0d",
                                     $realtime, got.reg_a, got.reg_b, got.zero_flag,
                                     got.prog_counter, got.fetched_op, got.status);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                request_taken = 1'b1;
                expected_regs_q.push_back(step_cpu(s_axis_tuser, s_axis_tdata[7:0],
                                                   s_axis_tdata[15:8]));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic queue_request(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] addr,
                                 logic [BYTE_W-1:0] data);
        t_request req;
        req.func = func;
        req.addr = addr;
        req.data = data;
        request_q.push_back(req);
        requests_queued++;
    endtask

    task automatic wait_drained();
        while (results_checked != requests_queued) @(posedge i_clk);
    endtask

    // Mostly short programs written to memory and then run; some stray requests
    task automatic queue_random_programs(int quota);
        int                start;
        int                n_instr;
        int                n_exec;
        int                pick;
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] prog[$];
        start = requests_queued;
        while (requests_queued - start < quota) begin
            if ($urandom_range(7) == 0) begin
                // noise: any function code, spare one included
                repeat ($urandom_range(1, 4))
                    queue_request(FUNC_W'($urandom_range(3)), BYTE_W'($urandom),
                                  BYTE_W'($urandom));
            end else begin
                prog.delete();
                if ($urandom_range(1) == 0) begin
                    queue_request(FN_CLEAR, BYTE_W'($urandom), BYTE_W'($urandom));
                    base = '0;   // PC is back at zero after a clear
                end else begin
                    base = BYTE_W'($urandom);
                end
                n_instr = $urandom_range(2, 8);
                repeat (n_instr) begin
                    pick = $urandom_range(99);
                    if (pick < 5) begin
                        prog.push_back(BYTE_W'($urandom_range(8, 255)));
                    end else if (pick < 10) begin
                        prog.push_back(OP_HALT);
                    end else if (pick < 25) begin
                        // load then add the negation: forces Z, then test it
                        value = BYTE_W'($urandom);
                        prog.push_back(OP_LDA);
                        prog.push_back(value);
                        prog.push_back(OP_ADDI);
                        prog.push_back(-value);
                        prog.push_back(OP_JZ);
                        prog.push_back(base + BYTE_W'($urandom_range(15)));
                    end else begin
                        value = BYTE_W'($urandom_range(OP_LDA, OP_JZ));
                        prog.push_back(value);
                        if (value == OP_JMP || value == OP_JZ)
                            prog.push_back(($urandom_range(3) == 0) ? BYTE_W'($urandom)
                                           : base + BYTE_W'($urandom_range(15)));
                        else if (value != OP_ADDB && value != OP_MOVAB)
                            prog.push_back(BYTE_W'($urandom));
                    end
                end
                foreach (prog[k])
                    queue_request(FN_WRITE, base + BYTE_W'(k), prog[k]);
                n_exec = n_instr + $urandom_range(4);
                repeat (n_exec)
                    queue_request(FN_EXEC, BYTE_W'($urandom), BYTE_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 1, no idling: directed sequence, then random programs
        queue_request(FN_EXEC, 8'h00, 8'h00);    // memory clear after reset: halt at 0
        queue_request(FN_CLEAR, 8'hFF, 8'hFF);
        queue_request(FN_WRITE, 8'h00, OP_LDA);
        queue_request(FN_WRITE, 8'h01, 8'hFF);
        queue_request(FN_WRITE, 8'h02, OP_ADDI);
        queue_request(FN_WRITE, 8'h03, 8'h01);   // FF + 1 wraps to zero, sets Z
        queue_request(FN_WRITE, 8'h04, OP_JZ);
        queue_request(FN_WRITE, 8'h05, 8'hFE);
        queue_request(FN_WRITE, 8'hFE, OP_LDB);
        queue_request(FN_WRITE, 8'hFF, 8'h80);   // operand at the top, PC wraps to 0
        repeat (4) queue_request(FN_EXEC, 8'h00, 8'h00);
        queue_request(FN_WRITE, 8'h00, OP_ADDB);
        queue_request(FN_WRITE, 8'h01, OP_MOVAB);
        queue_request(FN_WRITE, 8'h02, OP_JZ);   // Z now clear: target byte skipped
        queue_request(FN_WRITE, 8'h04, OP_JMP);
        queue_request(FN_WRITE, 8'h05, 8'h40);
        queue_request(FN_WRITE, 8'h41, 8'h08);   // lowest unknown opcode after a halt
        repeat (6) queue_request(FN_EXEC, 8'h00, 8'h00);
        queue_request(FN_SPARE, 8'hFF, 8'hFF);   // spare function code
        queue_random_programs(150);
        wait_drained();

        // Phase 2: sender mostly idle
        send_idle_pct  = 88;
        recv_stall_pct = 0;
        queue_random_programs(190);
        wait_drained();

        // Phase 3: receiver mostly stalling
        send_idle_pct  = 0;
        recv_stall_pct = 88;
        queue_random_programs(190);
        wait_drained();

        // Phase 4: light idling on both sides
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        queue_random_programs(190);
        wait_drained();

        // let any stray result show up
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_regs_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### tiny_accumulator_cpu_step.f
rtl/tacs_pkg.sv
rtl/tacs_ram.sv
rtl/tacs_exec.sv
rtl/tiny_accumulator_cpu_step.sv
dv/tb_tiny_accumulator_cpu_step.sv
